FILE: sv/debug_step_breakpoint_controller_core_defines.svh
// Assertion macros shared by the run-control block.
// No dependencies; included by the modules that carry assertions.
`ifndef DEBUG_STEP_BREAKPOINT_CONTROLLER_CORE_DEFINES_SVH
`define DEBUG_STEP_BREAKPOINT_CONTROLLER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define DSBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("dsbc: assertion failed");

// An implication whose consequence is checked in the cycle after the antecedent.
`define DSBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsbc: assertion failed");

`endif

FILE: sv/dsbc_pkg.sv
// Shared types and codes of the debugger run-control block.
// No dependencies; used by every module of the block.
package dsbc_pkg;

    // Function codes of an input beat.
    localparam logic [3:0] FUNC_CHECK     = 4'd0;
    localparam logic [3:0] FUNC_PAUSE     = 4'd1;
    localparam logic [3:0] FUNC_CONTINUE  = 4'd2;
    localparam logic [3:0] FUNC_STEP_INTO = 4'd3;
    localparam logic [3:0] FUNC_STEP_OVER = 4'd4;
    localparam logic [3:0] FUNC_STEP_OUT  = 4'd5;
    localparam logic [3:0] FUNC_ADD       = 4'd6;
    localparam logic [3:0] FUNC_REMOVE    = 4'd7;
    localparam logic [3:0] FUNC_SET_COND  = 4'd8;

    // Step modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_INTO = 2'd1;
    localparam logic [1:0] MODE_OVER = 2'd2;
    localparam logic [1:0] MODE_OUT  = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BAD_LOC = 2'd2;

    // Update request from the run control to the breakpoint table.
    typedef struct packed {
        logic claim;     // find or allocate an entry for the item's location
        logic set_cond;  // write the condition flag of the claimed entry
        logic cond_val;  // condition flag value
        logic remove;    // drop the entry that matches the item's location
    } t_tbl_req;

    // Lookup response of the breakpoint table.
    typedef struct packed {
        logic hit_any;   // item location is in the table
        logic hit_cond;  // matching entry carries a condition
        logic free_any;  // at least one entry is unused
        logic cur_hit;   // last checked location is in the table
    } t_tbl_rsp;

    // One result beat.
    typedef struct packed {
        logic       proceed;
        logic       paused;
        logic       blocked;
        logic [1:0] mode;
        logic       bp_present;
        logic [1:0] status;
    } t_result;

endpackage

FILE: sv/dsbc_bp_table.sv
// Breakpoint table: parallel-compare lookup, lowest-free allocation and update.
// Depends on dsbc_pkg and the assertion macro header.
`include "debug_step_breakpoint_controller_core_defines.svh"

module dsbc_bp_table #(
    parameter int BP_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_source_id,
    input  logic [15:0]         i_command_index,
    input  logic [15:0]         i_cur_source,
    input  logic [15:0]         i_cur_index,
    input  dsbc_pkg::t_tbl_req  i_req,
    output dsbc_pkg::t_tbl_rsp  o_rsp
);

    localparam int IdxW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;

    logic [BP_ENTRIES-1:0] r_valid;
    logic [BP_ENTRIES-1:0] r_has_cond;
    logic [15:0]           r_src [BP_ENTRIES];
    logic [15:0]           r_idx [BP_ENTRIES];

    logic [BP_ENTRIES-1:0] hit_vec;
    logic [BP_ENTRIES-1:0] cur_vec;
    logic                  free_any;
    logic [IdxW-1:0]       free_idx;
    logic                  alloc;

    // Compare every entry against the item location and the last checked one.
    always_comb begin
        for (int i = 0; i < BP_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_src[i] == i_source_id)
                         && (r_idx[i] == i_command_index);
            cur_vec[i] = r_valid[i] && (r_src[i] == i_cur_source)
                         && (r_idx[i] == i_cur_index);
        end
    end

    // Lowest unused entry.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = BP_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    assign o_rsp.hit_any  = |hit_vec;
    assign o_rsp.hit_cond = |(hit_vec & r_has_cond);
    assign o_rsp.free_any = free_any;
    assign o_rsp.cur_hit  = |cur_vec;

    assign alloc = i_req.claim && !(|hit_vec) && free_any;

    // Valid and condition flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_has_cond <= '0;
        end else if (alloc) begin
            r_valid[free_idx]    <= 1'b1;
            r_has_cond[free_idx] <= i_req.set_cond && i_req.cond_val;
        end else if (i_req.claim && i_req.set_cond) begin
            r_has_cond <= (r_has_cond & ~hit_vec)
                          | (hit_vec & {BP_ENTRIES{i_req.cond_val}});
        end else if (i_req.remove) begin
            r_valid    <= r_valid & ~hit_vec;
            r_has_cond <= r_has_cond & ~hit_vec;
        end
    end

    // Location payload of a newly allocated entry.
    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_src[free_idx] <= i_source_id;
            r_idx[free_idx] <= i_command_index;
        end
    end

    // A condition flag only ever sits on a used entry.
    `DSBC_ASSERT(a_cond_on_valid, i_clk, i_rst_n, (r_has_cond & ~r_valid) == '0)

endmodule

FILE: sv/dsbc_run_ctrl.sv
// Run control: pause, step and resume state and the per-beat decision.
// Depends on dsbc_pkg and the assertion macro header.
`include "debug_step_breakpoint_controller_core_defines.svh"

module dsbc_run_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [3:0]          i_func,
    input  logic [15:0]         i_source_id,
    input  logic [15:0]         i_command_index,
    input  logic [7:0]          i_call_depth,
    input  logic                i_cond_true,
    input  logic                i_cond_present,
    input  dsbc_pkg::t_tbl_rsp  i_rsp,
    output dsbc_pkg::t_tbl_req  o_req,
    output logic [15:0]         o_cur_source,
    output logic [15:0]         o_cur_index,
    output dsbc_pkg::t_result   o_res
);

    logic        r_paused, n_paused;
    logic        r_blocked, n_blocked;
    logic [1:0]  r_mode, n_mode;
    logic        r_exec, n_exec;
    logic [7:0]  r_origin, n_origin;
    logic        r_res_valid, n_res_valid;
    logic [15:0] r_res_src, n_res_src;
    logic [15:0] r_res_idx, n_res_idx;
    logic [15:0] r_cur_src, n_cur_src;
    logic [15:0] r_cur_idx, n_cur_idx;
    logic [7:0]  r_cur_depth, n_cur_depth;

    logic        loc_ok;
    logic        skip;
    logic        bp_hit;
    logic        add_like;
    logic        proceed;
    logic [1:0]  status;
    logic [1:0]  step_mode;

    assign loc_ok   = (i_source_id != '0) && !i_command_index[15];
    assign skip     = r_res_valid && (r_res_src == i_source_id)
                      && (r_res_idx == i_command_index);
    assign bp_hit   = i_rsp.hit_any && (!i_rsp.hit_cond || i_cond_true);
    assign add_like = (i_func == dsbc_pkg::FUNC_ADD) || (i_func == dsbc_pkg::FUNC_SET_COND);

    // Step mode selected by a step request.
    always_comb begin
        case (i_func)
            dsbc_pkg::FUNC_STEP_INTO: step_mode = dsbc_pkg::MODE_INTO;
            dsbc_pkg::FUNC_STEP_OVER: step_mode = dsbc_pkg::MODE_OVER;
            dsbc_pkg::FUNC_STEP_OUT:  step_mode = dsbc_pkg::MODE_OUT;
            default:                  step_mode = dsbc_pkg::MODE_NONE;
        endcase
    end

    // Next state and decision for the beat in the input register.
    always_comb begin
        n_paused    = r_paused;
        n_blocked   = r_blocked;
        n_mode      = r_mode;
        n_exec      = r_exec;
        n_origin    = r_origin;
        n_res_valid = r_res_valid;
        n_res_src   = r_res_src;
        n_res_idx   = r_res_idx;
        n_cur_src   = r_cur_src;
        n_cur_idx   = r_cur_idx;
        n_cur_depth = r_cur_depth;
        proceed     = 1'b0;
        status      = dsbc_pkg::STATUS_OK;
        case (i_func)
            dsbc_pkg::FUNC_CHECK: begin
                n_cur_src   = i_source_id;
                n_cur_idx   = i_command_index;
                n_cur_depth = i_call_depth;
                if (skip) begin
                    n_res_valid = 1'b0;
                end
                if (bp_hit && !skip
                    && (!r_paused || (r_mode != dsbc_pkg::MODE_NONE && r_exec))) begin
                    n_paused  = 1'b1;
                    n_blocked = 1'b1;
                    n_mode    = dsbc_pkg::MODE_NONE;
                end else if (!r_paused) begin
                    n_blocked = 1'b0;
                    proceed   = 1'b1;
                end else if (r_mode == dsbc_pkg::MODE_INTO || r_mode == dsbc_pkg::MODE_OVER) begin
                    if (!r_exec) begin
                        n_exec    = 1'b1;
                        n_blocked = 1'b0;
                        proceed   = 1'b1;
                    end else if (r_mode == dsbc_pkg::MODE_OVER && i_call_depth > r_origin) begin
                        n_blocked = 1'b0;
                        proceed   = 1'b1;
                    end else begin
                        n_mode    = dsbc_pkg::MODE_NONE;
                        n_blocked = 1'b1;
                    end
                end else if (r_mode == dsbc_pkg::MODE_OUT) begin
                    n_exec = 1'b1;
                    if (i_call_depth >= r_origin) begin
                        n_blocked = 1'b0;
                        proceed   = 1'b1;
                    end else begin
                        n_mode    = dsbc_pkg::MODE_NONE;
                        n_blocked = 1'b1;
                    end
                end else begin
                    n_blocked = 1'b1;
                end
            end
            dsbc_pkg::FUNC_PAUSE: begin
                n_paused = 1'b1;
                n_mode   = dsbc_pkg::MODE_NONE;
                n_exec   = 1'b0;
            end
            dsbc_pkg::FUNC_CONTINUE: begin
                // Arm the one-shot skip when resuming from a breakpoint stop.
                if (r_blocked && i_rsp.cur_hit) begin
                    n_res_valid = 1'b1;
                    n_res_src   = r_cur_src;
                    n_res_idx   = r_cur_idx;
                end
                n_paused  = 1'b0;
                n_blocked = 1'b0;
                n_mode    = dsbc_pkg::MODE_NONE;
                n_exec    = 1'b0;
            end
            dsbc_pkg::FUNC_STEP_INTO, dsbc_pkg::FUNC_STEP_OVER,
            dsbc_pkg::FUNC_STEP_OUT: begin
                n_paused  = 1'b1;
                n_blocked = 1'b0;
                n_mode    = step_mode;
                n_exec    = 1'b0;
                n_origin  = r_cur_depth;
                // Step out never uses an origin below depth one.
                if (step_mode == dsbc_pkg::MODE_OUT && r_cur_depth == '0) begin
                    n_origin = 8'd1;
                end
            end
            dsbc_pkg::FUNC_ADD, dsbc_pkg::FUNC_SET_COND: begin
                if (!loc_ok) begin
                    status = dsbc_pkg::STATUS_BAD_LOC;
                end else if (!i_rsp.hit_any && !i_rsp.free_any) begin
                    status = dsbc_pkg::STATUS_FULL;
                end
            end
            dsbc_pkg::FUNC_REMOVE: begin
                if (!loc_ok) begin
                    status = dsbc_pkg::STATUS_BAD_LOC;
                end else if (skip) begin
                    n_res_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Table update request.
    assign o_req.claim    = i_vld && add_like && loc_ok;
    assign o_req.set_cond = i_func == dsbc_pkg::FUNC_SET_COND;
    assign o_req.cond_val = i_cond_present;
    assign o_req.remove   = i_vld && (i_func == dsbc_pkg::FUNC_REMOVE) && loc_ok;

    assign o_cur_source = r_cur_src;
    assign o_cur_index  = r_cur_idx;

    // Result of the beat, with table presence as it stands after the update.
    assign o_res.proceed    = proceed;
    assign o_res.paused     = n_paused;
    assign o_res.blocked    = n_blocked;
    assign o_res.mode       = n_mode;
    assign o_res.bp_present = (i_rsp.hit_any && (i_func != dsbc_pkg::FUNC_REMOVE))
                              || (add_like && loc_ok && i_rsp.free_any);
    assign o_res.status     = status;

    // State registers, advanced once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused    <= 1'b0;
            r_blocked   <= 1'b0;
            r_mode      <= dsbc_pkg::MODE_NONE;
            r_exec      <= 1'b0;
            r_origin    <= '0;
            r_res_valid <= 1'b0;
            r_res_src   <= '0;
            r_res_idx   <= '0;
            r_cur_src   <= '0;
            r_cur_idx   <= '0;
            r_cur_depth <= '0;
        end else if (i_vld) begin
            r_paused    <= n_paused;
            r_blocked   <= n_blocked;
            r_mode      <= n_mode;
            r_exec      <= n_exec;
            r_origin    <= n_origin;
            r_res_valid <= n_res_valid;
            r_res_src   <= n_res_src;
            r_res_idx   <= n_res_idx;
            r_cur_src   <= n_cur_src;
            r_cur_idx   <= n_cur_idx;
            r_cur_depth <= n_cur_depth;
        end
    end

    // A command is only ever held while the unit is paused.
    `DSBC_ASSERT(a_blocked_paused, i_clk, i_rst_n, !r_blocked || r_paused)
    // An active step exists only while paused.
    `DSBC_ASSERT(a_step_paused, i_clk, i_rst_n, (r_mode == dsbc_pkg::MODE_NONE) || r_paused)
    // Step out always measures against a nonzero origin.
    `DSBC_ASSERT(a_out_origin, i_clk, i_rst_n, (r_mode != dsbc_pkg::MODE_OUT) || (r_origin != '0))

endmodule

FILE: sv/debug_step_breakpoint_controller_core.sv
// Top level of the debugger run-control block: input register, run control,
// breakpoint table and result register. Depends on dsbc_pkg, dsbc_bp_table,
// dsbc_run_ctrl and the assertion macro header.
//
// Usage:
//   A beat is taken at a rising edge where start is high and busy is low.
//   busy stays low: the block takes one beat in every cycle.
//   Each beat carries a function code and a location; it is either a check of
//   a command about to run or a run-control or breakpoint-table request.
//   Exactly one result comes back per beat on the o_ ports, marked by o_strobe
//   for one cycle, in beat order, after the input register and the result register.
//   Throughput is one beat per cycle; the state update for a beat (flags and
//   a parallel compare over all BP_ENTRIES table entries) is combinational
//   between the input register and the result register.
//   The receiver cannot stall: a result must be taken in its strobe cycle.
//   Synchronous reset (i_rst_n low) clears the run flags, the resume key, the
//   table's valid and condition flags and any beat in flight; no clearing pass
//   is needed afterwards.
`include "debug_step_breakpoint_controller_core_defines.svh"

module debug_step_breakpoint_controller_core #(
    parameter int BP_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic [15:0]        i_source_id,
    input  logic signed [15:0] i_command_index,
    input  logic [7:0]         i_call_depth,
    input  logic               i_cond_true,
    input  logic               i_cond_present,
    output logic               o_strobe,
    output logic               o_proceed,
    output logic               o_is_paused,
    output logic               o_is_blocked,
    output logic [1:0]         o_mode_now,
    output logic               o_bp_present,
    output logic [1:0]         o_status
);

    logic        r_vld;
    logic [3:0]  r_func;
    logic [15:0] r_src;
    logic [15:0] r_idx;
    logic [7:0]  r_depth;
    logic        r_cond;
    logic        r_present;

    logic                r_strobe;
    dsbc_pkg::t_result   r_res;

    dsbc_pkg::t_tbl_req  tbl_req;
    dsbc_pkg::t_tbl_rsp  tbl_rsp;
    dsbc_pkg::t_result   res;
    logic [15:0]         cur_src;
    logic [15:0]         cur_idx;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= i_func;
            r_src     <= i_source_id;
            r_idx     <= $unsigned(i_command_index);
            r_depth   <= i_call_depth;
            r_cond    <= i_cond_true;
            r_present <= i_cond_present;
        end
    end

    // Breakpoint table.
    dsbc_bp_table #(
        .BP_ENTRIES(BP_ENTRIES)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_source_id    (r_src),
        .i_command_index(r_idx),
        .i_cur_source   (cur_src),
        .i_cur_index    (cur_idx),
        .i_req          (tbl_req),
        .o_rsp          (tbl_rsp)
    );

    // Run control.
    dsbc_run_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (r_vld),
        .i_func         (r_func),
        .i_source_id    (r_src),
        .i_command_index(r_idx),
        .i_call_depth   (r_depth),
        .i_cond_true    (r_cond),
        .i_cond_present (r_present),
        .i_rsp          (tbl_rsp),
        .o_req          (tbl_req),
        .o_cur_source   (cur_src),
        .o_cur_index    (cur_idx),
        .o_res          (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_res <= res;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_proceed    = r_res.proceed;
    assign o_is_paused  = r_res.paused;
    assign o_is_blocked = r_res.blocked;
    assign o_mode_now   = r_res.mode;
    assign o_bp_present = r_res.bp_present;
    assign o_status     = r_res.status;

    // A beat in the input register always produces a result beat next.
    `DSBC_ASSERT_NEXT(a_beat_to_result, i_clk, i_rst_n, r_vld, r_strobe)

endmodule
